// ----- src/filtered_power_energy_meter_macros.svh -----
// Assertion macros for the power meter.
`ifndef FILTERED_POWER_ENERGY_METER_MACROS_SVH
`define FILTERED_POWER_ENERGY_METER_MACROS_SVH
`ifndef SYNTHESIS
`define FPEM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fpem: check failed");
`define FPEM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("fpem: check failed");
`else
`define FPEM_ASSERT(label, clk, rst, prop)
`define FPEM_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// ----- src/fpem_pkg.sv -----
package fpem_pkg;

   localparam int SAMPLE_BITS_DEF   = 12;
   localparam int OUT_FRAC_BITS_DEF = 16;

   localparam int GAIN_W     = 24;
   localparam int FRAC_W     = 24;
   localparam int PERIOD_W   = 32;
   localparam int E_SPLIT    = 16;
   localparam int STATE_W    = 48;
   localparam int VOUT_W     = 32;
   localparam int POUT_W     = 48;
   localparam int EOUT_W     = 64;
   localparam int MUL_W      = 33;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int STEP_BITS  = 4;

   localparam logic [GAIN_W-1:0] WEIGHT_RESET = GAIN_W'(3355);

   typedef logic [STEP_BITS-1:0] step_type;

   // microcode addresses
   localparam step_type ST_IDLE    = STEP_BITS'(0);
   localparam step_type ST_XV      = STEP_BITS'(1);
   localparam step_type ST_XC      = STEP_BITS'(2);
   localparam step_type ST_DHV     = STEP_BITS'(3);
   localparam step_type ST_DLV     = STEP_BITS'(4);
   localparam step_type ST_DHC     = STEP_BITS'(5);
   localparam step_type ST_DLC     = STEP_BITS'(6);
   localparam step_type ST_SC      = STEP_BITS'(7);
   localparam step_type ST_VC      = STEP_BITS'(8);
   localparam step_type ST_PWR     = STEP_BITS'(9);
   localparam step_type ST_PH      = STEP_BITS'(10);
   localparam step_type ST_PL      = STEP_BITS'(11);
   localparam step_type ST_ACC     = STEP_BITS'(12);
   localparam step_type ST_ENERGY  = STEP_BITS'(13);

   typedef enum logic [3:0] {
      MUL_NONE, MUL_XV, MUL_XC, MUL_DHV, MUL_DLV, MUL_DHC, MUL_DLC,
      MUL_VC, MUL_PH, MUL_PL
   } mul_op_type;

   typedef enum logic [3:0] {
      ALU_NOP, ALU_LOAD, ALU_DV, ALU_DC, ALU_ACC_SET, ALU_SV, ALU_SC,
      ALU_PWR, ALU_ACC_ADD, ALU_ENERGY
   } alu_op_type;

   typedef enum logic [1:0] {
      COND_NONE, COND_IN, COND_OUT
   } cond_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ZERO_V, CSR_ZERO_C, CSR_GAIN_V, CSR_GAIN_C, CSR_WEIGHT, CSR_PERIOD
   } csr_reg_type;

   typedef struct packed {
      mul_op_type mul;
      alu_op_type alu;
      cond_type   cond;
      logic       jump;
      step_type   target;
   } ctl_word_type;

   typedef struct packed {
      mul_op_type mul;
      alu_op_type alu;
      logic       fire;
   } dp_ctl_type;

   // product issued in step k is in the product register during step k+1
   function automatic ctl_word_type ucode(input step_type step);
      ctl_word_type w;
      w = '{MUL_NONE, ALU_NOP, COND_NONE, 1'b1, ST_IDLE};
      case (step)
         ST_IDLE:   w = '{MUL_NONE, ALU_LOAD,    COND_IN,   1'b0, ST_IDLE};
         ST_XV:     w = '{MUL_XV,   ALU_NOP,     COND_NONE, 1'b0, ST_IDLE};
         ST_XC:     w = '{MUL_XC,   ALU_DV,      COND_NONE, 1'b0, ST_IDLE};
         ST_DHV:    w = '{MUL_DHV,  ALU_DC,      COND_NONE, 1'b0, ST_IDLE};
         ST_DLV:    w = '{MUL_DLV,  ALU_ACC_SET, COND_NONE, 1'b0, ST_IDLE};
         ST_DHC:    w = '{MUL_DHC,  ALU_SV,      COND_NONE, 1'b0, ST_IDLE};
         ST_DLC:    w = '{MUL_DLC,  ALU_ACC_SET, COND_NONE, 1'b0, ST_IDLE};
         ST_SC:     w = '{MUL_NONE, ALU_SC,      COND_NONE, 1'b0, ST_IDLE};
         ST_VC:     w = '{MUL_VC,   ALU_NOP,     COND_NONE, 1'b0, ST_IDLE};
         ST_PWR:    w = '{MUL_NONE, ALU_PWR,     COND_NONE, 1'b0, ST_IDLE};
         ST_PH:     w = '{MUL_PH,   ALU_NOP,     COND_NONE, 1'b0, ST_IDLE};
         ST_PL:     w = '{MUL_PL,   ALU_ACC_SET, COND_NONE, 1'b0, ST_IDLE};
         ST_ACC:    w = '{MUL_NONE, ALU_ACC_ADD, COND_NONE, 1'b0, ST_IDLE};
         ST_ENERGY: w = '{MUL_NONE, ALU_ENERGY,  COND_OUT,  1'b1, ST_IDLE};
         default:   w = '{MUL_NONE, ALU_NOP,     COND_NONE, 1'b1, ST_IDLE};
      endcase
      return w;
   endfunction

   function automatic logic signed [VOUT_W-1:0] sat_48_32(input logic signed [47:0] x);
      logic signed [VOUT_W-1:0] r;
      if ((&x[47:31]) || !(|x[47:31])) begin
         r = x[31:0];
      end else if (x[47]) begin
         r = {1'b1, {31{1'b0}}};
      end else begin
         r = {1'b0, {31{1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [POUT_W-1:0] sat_66_48(input logic signed [65:0] x);
      logic signed [POUT_W-1:0] r;
      if ((&x[65:47]) || !(|x[65:47])) begin
         r = x[47:0];
      end else if (x[65]) begin
         r = {1'b1, {47{1'b0}}};
      end else begin
         r = {1'b0, {47{1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [EOUT_W-1:0] sat_66_64(input logic signed [65:0] x);
      logic signed [EOUT_W-1:0] r;
      if ((&x[65:63]) || !(|x[65:63])) begin
         r = x[63:0];
      end else if (x[65]) begin
         r = {1'b1, {63{1'b0}}};
      end else begin
         r = {1'b0, {63{1'b1}}};
      end
      return r;
   endfunction

endpackage

// ----- src/filtered_power_energy_meter.sv -----
// Power meter with low-pass smoothing: each item of one voltage and one current ADC code
// yields the filtered voltage, filtered current, their product and the saturating energy
// total. The result is written to the output register by the last microcode step, and a new item can be
// accepted only in the idle step (later still while a previous result is not yet taken); one
// shared 33x33 multiplier computes the item's nine products in turn under a 14-step
// microcode program. A new item is accepted while the previous result waits in the output
// register.
// Configuration writes are registered, take effect in the next cycle and are always accepted;
// write only when the block is idle. No clearing pass follows reset.
module filtered_power_energy_meter #(
   parameter int SAMPLE_BITS   = fpem_pkg::SAMPLE_BITS_DEF,
   parameter int OUT_FRAC_BITS = fpem_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [SAMPLE_BITS-1:0]              req_voltage_sample,
   input  logic [SAMPLE_BITS-1:0]              req_current_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [fpem_pkg::VOUT_W-1:0]  rsp_voltage_out,
   output logic signed [fpem_pkg::VOUT_W-1:0]  rsp_current_out,
   output logic signed [fpem_pkg::POUT_W-1:0]  rsp_power_out,
   output logic signed [fpem_pkg::EOUT_W-1:0]  rsp_energy_out,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fpem_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fpem_pkg::CSR_DATA_W-1:0]     csr_data
);

   fpem_pkg::dp_ctl_type ctl;

   assign csr_ready = 1'b1;

   fpem_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   fpem_dp #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .req_voltage_sample (req_voltage_sample),
      .req_current_sample (req_current_sample),
      .csr_valid          (csr_valid & csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_voltage_out    (rsp_voltage_out),
      .rsp_current_out    (rsp_current_out),
      .rsp_power_out      (rsp_power_out),
      .rsp_energy_out     (rsp_energy_out)
   );

endmodule

// ----- src/fpem_seq.sv -----
`include "filtered_power_energy_meter_macros.svh"

module fpem_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fpem_pkg::dp_ctl_type   ctl
);

   fpem_pkg::step_type     step_ff;
   fpem_pkg::step_type     step_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   fpem_pkg::ctl_word_type cw;
   logic                   hold;

   assign cw = fpem_pkg::ucode(step_ff);

   always_comb begin
      case (cw.cond)
         fpem_pkg::COND_IN:  hold = !req_valid;
         fpem_pkg::COND_OUT: hold = rsp_valid_ff && !rsp_ready;
         default:            hold = 1'b0;
      endcase

      if (hold) begin
         step_in = step_ff;
      end else if (cw.jump) begin
         step_in = cw.target;
      end else begin
         step_in = fpem_pkg::STEP_BITS'(step_ff + 1'b1);
      end

      if (!hold && cw.alu == fpem_pkg::ALU_ENERGY) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= fpem_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (cw.cond == fpem_pkg::COND_IN);
   assign rsp_valid = rsp_valid_ff;
   assign ctl.mul   = cw.mul;
   assign ctl.alu   = cw.alu;
   assign ctl.fire  = !hold;

   `FPEM_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, step_ff == fpem_pkg::ST_XV)
   `FPEM_ASSERT(a_step_range, clock, reset, step_ff <= fpem_pkg::ST_ENERGY)
   `FPEM_ASSERT(a_rsp_from_last, clock, reset, $rose(rsp_valid_ff) |-> $past(step_ff) == fpem_pkg::ST_ENERGY)
   `FPEM_ASSERT_NEXT(a_stall_holds, clock, reset, step_ff == fpem_pkg::ST_ENERGY && rsp_valid_ff && !rsp_ready, step_ff == fpem_pkg::ST_ENERGY && rsp_valid_ff)

endmodule

// ----- src/fpem_dp.sv -----
module fpem_dp #(
   parameter int SAMPLE_BITS   = fpem_pkg::SAMPLE_BITS_DEF,
   parameter int OUT_FRAC_BITS = fpem_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  fpem_pkg::dp_ctl_type                    ctl,
   input  logic [SAMPLE_BITS-1:0]                  req_voltage_sample,
   input  logic [SAMPLE_BITS-1:0]                  req_current_sample,
   input  logic                                    csr_valid,
   input  logic [fpem_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [fpem_pkg::CSR_DATA_W-1:0]         csr_data,
   output logic signed [fpem_pkg::VOUT_W-1:0]      rsp_voltage_out,
   output logic signed [fpem_pkg::VOUT_W-1:0]      rsp_current_out,
   output logic signed [fpem_pkg::POUT_W-1:0]      rsp_power_out,
   output logic signed [fpem_pkg::EOUT_W-1:0]      rsp_energy_out
);

   localparam int DIFF_W = SAMPLE_BITS + 1;
   localparam int MW     = fpem_pkg::MUL_W;
   localparam int PRW    = fpem_pkg::PROD_W;
   localparam int GW     = fpem_pkg::GAIN_W;
   localparam int FW     = fpem_pkg::FRAC_W;
   localparam int TW     = fpem_pkg::PERIOD_W;
   localparam int ES     = fpem_pkg::E_SPLIT;
   localparam int STW    = fpem_pkg::STATE_W;
   localparam int VW     = fpem_pkg::VOUT_W;
   localparam int PWW    = fpem_pkg::POUT_W;
   localparam int EW     = fpem_pkg::EOUT_W;
   localparam int SHIFT_V = FW - OUT_FRAC_BITS;

   // configuration
   logic [SAMPLE_BITS-1:0] zv_ff, zv_in, zc_ff, zc_in;
   logic [GW-1:0]          gv_ff, gv_in, gc_ff, gc_in, w_ff, w_in;
   logic [TW-1:0]          t_ff, t_in;

   // state
   logic signed [STW-1:0]  sv_ff, sv_in, sc_ff, sc_in;
   logic signed [EW-1:0]   energy_ff, energy_in;

   // working registers
   logic [SAMPLE_BITS-1:0] vs_ff, vs_in, cs_ff, cs_in;
   logic signed [STW-1:0]  dv_ff, dv_in, dc_ff, dc_in;
   logic signed [PRW-1:0]  prod_ff, prod_in, acc_ff, acc_in;
   logic signed [VW-1:0]   vo_ff, vo_in, co_ff, co_in;
   logic signed [PWW-1:0]  p_ff, p_in;

   // result item
   logic signed [VW-1:0]   rv_ff, rv_in, rc_ff, rc_in;
   logic signed [PWW-1:0]  rp_ff, rp_in;
   logic signed [EW-1:0]   re_ff, re_in;

   logic signed [DIFF_W-1:0] diff_v, diff_c;
   logic signed [MW-1:0]     mul_a, mul_b;
   logic signed [MW-1:0]     w_op, t_op;
   logic signed [STW-1:0]    st_sel, d_new, f_sum;
   logic signed [VW-1:0]     f_sat;
   logic signed [PWW-1:0]    p_new;
   logic signed [PRW-1:0]    acc_sum, e_sum;
   logic signed [EW-1:0]     e_new;

   assign diff_v = $signed({1'b0, vs_ff}) - $signed({1'b0, zv_ff});
   assign diff_c = $signed({1'b0, cs_ff}) - $signed({1'b0, zc_ff});
   assign w_op   = $signed({{(MW-GW){1'b0}}, w_ff});
   assign t_op   = $signed({{(MW-TW){1'b0}}, t_ff});

   always_comb begin
      case (ctl.mul)
         fpem_pkg::MUL_XV: begin
            mul_a = MW'(diff_v);
            mul_b = $signed({{(MW-GW){1'b0}}, gv_ff});
         end
         fpem_pkg::MUL_XC: begin
            mul_a = MW'(diff_c);
            mul_b = $signed({{(MW-GW){1'b0}}, gc_ff});
         end
         fpem_pkg::MUL_DHV: begin
            mul_a = MW'($signed(dv_ff[STW-1:FW]));
            mul_b = w_op;
         end
         fpem_pkg::MUL_DLV: begin
            mul_a = $signed({{(MW-FW){1'b0}}, dv_ff[FW-1:0]});
            mul_b = w_op;
         end
         fpem_pkg::MUL_DHC: begin
            mul_a = MW'($signed(dc_ff[STW-1:FW]));
            mul_b = w_op;
         end
         fpem_pkg::MUL_DLC: begin
            mul_a = $signed({{(MW-FW){1'b0}}, dc_ff[FW-1:0]});
            mul_b = w_op;
         end
         fpem_pkg::MUL_VC: begin
            mul_a = MW'(vo_ff);
            mul_b = MW'(co_ff);
         end
         fpem_pkg::MUL_PH: begin
            mul_a = MW'($signed(p_ff[PWW-1:ES]));
            mul_b = t_op;
         end
         fpem_pkg::MUL_PL: begin
            mul_a = $signed({{(MW-ES){1'b0}}, p_ff[ES-1:0]});
            mul_b = t_op;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // filter: s + d*w/2^24 = s + dh*w + floor(dl*w/2^24)
   assign st_sel  = (ctl.alu == fpem_pkg::ALU_DC || ctl.alu == fpem_pkg::ALU_SC) ? sc_ff : sv_ff;
   assign d_new   = $signed(prod_ff[STW-1:0]) - st_sel;
   assign f_sum   = st_sel + $signed(acc_ff[STW-1:0])
                    + $signed({{(STW-FW){1'b0}}, prod_ff[2*FW-1:FW]});
   assign f_sat   = fpem_pkg::sat_48_32(f_sum >>> SHIFT_V);
   assign p_new   = fpem_pkg::sat_66_48(prod_ff >>> OUT_FRAC_BITS);
   assign acc_sum = acc_ff + $signed({{ES{1'b0}}, prod_ff[PRW-1:ES]});
   assign e_sum   = PRW'(energy_ff) + (acc_ff >>> ES);
   assign e_new   = fpem_pkg::sat_66_64(e_sum);

   always_comb begin
      zv_in = zv_ff;
      zc_in = zc_ff;
      gv_in = gv_ff;
      gc_in = gc_ff;
      w_in  = w_ff;
      t_in  = t_ff;
      sv_in = sv_ff;
      sc_in = sc_ff;
      energy_in = energy_ff;
      vs_in = vs_ff;
      cs_in = cs_ff;
      dv_in = dv_ff;
      dc_in = dc_ff;
      acc_in = acc_ff;
      vo_in = vo_ff;
      co_in = co_ff;
      p_in  = p_ff;
      rv_in = rv_ff;
      rc_in = rc_ff;
      rp_in = rp_ff;
      re_in = re_ff;

      if (csr_valid) begin
         case (csr_index)
            fpem_pkg::CSR_ZERO_V: zv_in = csr_data[SAMPLE_BITS-1:0];
            fpem_pkg::CSR_ZERO_C: zc_in = csr_data[SAMPLE_BITS-1:0];
            fpem_pkg::CSR_GAIN_V: gv_in = csr_data[GW-1:0];
            fpem_pkg::CSR_GAIN_C: gc_in = csr_data[GW-1:0];
            fpem_pkg::CSR_WEIGHT: w_in  = csr_data[GW-1:0];
            fpem_pkg::CSR_PERIOD: t_in  = csr_data[TW-1:0];
            default: ;
         endcase
      end

      if (ctl.fire) begin
         case (ctl.alu)
            fpem_pkg::ALU_LOAD: begin
               vs_in = req_voltage_sample;
               cs_in = req_current_sample;
            end
            fpem_pkg::ALU_DV:      dv_in  = d_new;
            fpem_pkg::ALU_DC:      dc_in  = d_new;
            fpem_pkg::ALU_ACC_SET: acc_in = prod_ff;
            fpem_pkg::ALU_SV: begin
               sv_in = f_sum;
               vo_in = f_sat;
            end
            fpem_pkg::ALU_SC: begin
               sc_in = f_sum;
               co_in = f_sat;
            end
            fpem_pkg::ALU_PWR:     p_in   = p_new;
            fpem_pkg::ALU_ACC_ADD: acc_in = acc_sum;
            fpem_pkg::ALU_ENERGY: begin
               energy_in = e_new;
               rv_in = vo_ff;
               rc_in = co_ff;
               rp_in = p_ff;
               re_in = e_new;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zv_ff     <= '0;
         zc_ff     <= '0;
         gv_ff     <= '0;
         gc_ff     <= '0;
         w_ff      <= fpem_pkg::WEIGHT_RESET;
         t_ff      <= '0;
         sv_ff     <= '0;
         sc_ff     <= '0;
         energy_ff <= '0;
      end else begin
         zv_ff     <= zv_in;
         zc_ff     <= zc_in;
         gv_ff     <= gv_in;
         gc_ff     <= gc_in;
         w_ff      <= w_in;
         t_ff      <= t_in;
         sv_ff     <= sv_in;
         sc_ff     <= sc_in;
         energy_ff <= energy_in;
      end
   end

   always_ff @(posedge clock) begin
      vs_ff   <= vs_in;
      cs_ff   <= cs_in;
      dv_ff   <= dv_in;
      dc_ff   <= dc_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      vo_ff   <= vo_in;
      co_ff   <= co_in;
      p_ff    <= p_in;
      rv_ff   <= rv_in;
      rc_ff   <= rc_in;
      rp_ff   <= rp_in;
      re_ff   <= re_in;
   end

   assign rsp_voltage_out = rv_ff;
   assign rsp_current_out = rc_ff;
   assign rsp_power_out   = rp_ff;
   assign rsp_energy_out  = re_ff;

endmodule
